FILE: hdl/sms_pkg.sv
// Shared types, constants and command codes for the sequenced message store.
`timescale 1ns / 1ps
package sms_pkg;
  localparam int ENTRIES_DEF      = 1024;
  localparam int ARENA_BYTES_DEF  = 65536;
  localparam int MAX_TYPE_LEN_DEF = 8;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_HEADER = 3'd1,
    CMD_BODY   = 3'd2,
    CMD_LOWER  = 3'd3,
    CMD_READE  = 3'd4,
    CMD_READB  = 3'd5
  } cmd_t;

  localparam logic REG_MSG_LIMIT  = 1'b0;
  localparam logic REG_BYTE_LIMIT = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the request
    logic exec;       // perform simple commands / start a read
    logic search_rd;  // issue the read of the search midpoint
    logic search_upd; // narrow the search window using read data
    logic hdr_rd;     // read the last entry's sequence
    logic hdr_commit; // judge and commit the header
    logic finish;     // assemble the result
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic cmd_lower;
    logic cmd_header;
    logic cmd_read;
    logic search_done;
  } sts_t;
endpackage

FILE: hdl/sequenced_message_store_top.sv
// Top level of the sequenced message store: stream ports, config port, wiring.
// Sequence: clear, body byte and unknown commands pass EXEC, FIN and OUT; header and reads
// also pass HWT; lower bound repeats SRD, SWT and SUPD per search step, up to 11 steps
// for 1024 entries (one meta memory port).
// Throughput: one request at a time; next request accepted the cycle after the result is taken.
// Reset (rst, synchronous, active high): counters and drop count cleared, limits at maxima.
`timescale 1ns / 1ps
module sequenced_message_store_top #(
  parameter int ENTRIES      = sms_pkg::ENTRIES_DEF,
  parameter int ARENA_BYTES  = sms_pkg::ARENA_BYTES_DEF,
  parameter int MAX_TYPE_LEN = sms_pkg::MAX_TYPE_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cmd[2:0], seq[66:3], type_bytes[130:67], type_count[134:131], send_time[198:135],
  // body_len[215:199], data_byte[223:216], entry_index[233:224], byte_address[249:234]
  input  logic [255:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // accepted[0], position[11:1], out_seq[75:12], out_send_time[139:76],
  // out_type_bytes[203:140], out_type_count[207:204], body_offset[223:208],
  // body_length[240:224], out_byte[248:241], entry_count[259:249],
  // dropped_count[291:260]
  output logic [295:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [16:0]  cfg_data
);
  sms_pkg::ctl_t ctl;
  sms_pkg::sts_t sts;
  logic [294:0]  result;

  // Accept config writes at any time; the user must issue them only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;
  assign m_tdata = {1'b0, result};

  sms_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .sts(sts), .ctl(ctl)
  );

  sms_datapath #(.ENTRIES(ENTRIES), .ARENA_BYTES(ARENA_BYTES),
                 .MAX_TYPE_LEN(MAX_TYPE_LEN)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .cfg_we(cfg_valid), .cfg_sel(cfg_index[0]), .cfg_val(cfg_data),
    .i_cmd(s_tdata[2:0]), .i_seq(s_tdata[66:3]), .i_tbytes(s_tdata[130:67]),
    .i_tlen(s_tdata[134:131]), .i_when(s_tdata[198:135]), .i_blen(s_tdata[215:199]),
    .i_dbyte(s_tdata[223:216]), .i_idx(s_tdata[233:224]), .i_addr(s_tdata[249:234]),
    .result(result)
  );
endmodule

FILE: hdl/sms_ctrl.sv
// Controller state machine of the sequenced message store.
`timescale 1ns / 1ps
module sms_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sms_pkg::sts_t sts,
  output sms_pkg::ctl_t ctl
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EXEC = 9'b000000010,
    S_SRD  = 9'b000000100,
    S_SWT  = 9'b000001000,
    S_SUPD = 9'b000010000,
    S_HRD  = 9'b000100000,
    S_HWT  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   rd_wait;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign rd_wait = 1'b0;

  always_comb begin
    state_next = state;
    ctl = '0;
    in_ready = (state == S_IDLE) && !rd_wait;
    out_valid = (state == S_OUT);
    unique case (state)
      S_IDLE: if (in_valid) begin
        ctl.load = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.cmd_lower) state_next = S_SRD;
        else if (sts.cmd_header) begin
          ctl.hdr_rd = 1'b1;
          state_next = S_HWT;
        end else begin
          ctl.exec = 1'b1;
          state_next = sts.cmd_read ? S_HWT : S_FIN;
        end
      end
      S_SRD: begin
        if (sts.search_done) state_next = S_FIN;
        else begin
          ctl.search_rd = 1'b1;
          state_next = S_SWT;
        end
      end
      S_SWT: state_next = S_SUPD;
      S_SUPD: begin
        ctl.search_upd = 1'b1;
        state_next = S_SRD;
      end
      S_HRD: state_next = S_HWT;
      S_HWT: begin
        if (sts.cmd_header) ctl.hdr_commit = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: hdl/sms_datapath.sv
// Datapath of the sequenced message store: entry and arena memories, counters.
`timescale 1ns / 1ps
module sms_datapath #(
  parameter int ENTRIES      = sms_pkg::ENTRIES_DEF,
  parameter int ARENA_BYTES  = sms_pkg::ARENA_BYTES_DEF,
  parameter int MAX_TYPE_LEN = sms_pkg::MAX_TYPE_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  sms_pkg::ctl_t ctl,
  output sms_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic          cfg_sel,
  input  logic [16:0]   cfg_val,
  input  logic [2:0]    i_cmd,
  input  logic [63:0]   i_seq,
  input  logic [63:0]   i_tbytes,
  input  logic [3:0]    i_tlen,
  input  logic [63:0]   i_when,
  input  logic [16:0]   i_blen,
  input  logic [7:0]    i_dbyte,
  input  logic [9:0]    i_idx,
  input  logic [15:0]   i_addr,
  output logic [294:0]  result
);
  localparam int EW = $clog2(ENTRIES);
  localparam int AW = $clog2(ARENA_BYTES);
  localparam int CW = EW + 1;
  localparam int BW = AW + 1;
  localparam int MW = 64 + 64 + 64 + 4 + 16 + 17;

  logic [MW-1:0] meta_mem [ENTRIES];
  logic [7:0]    arena [ARENA_BYTES];
  logic [MW-1:0] meta_q;
  logic [7:0]    byte_q;
  logic [EW-1:0] meta_ra;

  logic [2:0]  cmd;
  logic [63:0] seq, tbytes, when;
  logic [3:0]  tlen;
  logic [16:0] blen;
  logic [7:0]  dbyte;
  logic [9:0]  idx;
  logic [15:0] addr;

  logic [10:0] msg_limit;
  logic [16:0] byte_limit;
  logic [CW-1:0] count;
  logic [BW-1:0] used, cursor;
  logic [16:0] pending;
  logic [31:0] drops;
  logic [CW-1:0] lo, hi, mid;
  logic        ok;
  logic        ok_read;
  logic        body_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_limit <= 11'd1024;
      byte_limit <= 17'd65536;
    end else if (cfg_we) begin
      if (cfg_sel == sms_pkg::REG_MSG_LIMIT) msg_limit <= cfg_val[10:0];
      else byte_limit <= cfg_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= i_cmd; seq <= i_seq; tbytes <= i_tbytes; tlen <= i_tlen;
      when <= i_when; blen <= i_blen; dbyte <= i_dbyte; idx <= i_idx; addr <= i_addr;
    end
  end

  assign sts.cmd_lower   = (cmd == sms_pkg::CMD_LOWER);
  assign sts.cmd_header  = (cmd == sms_pkg::CMD_HEADER);
  assign sts.cmd_read    = (cmd == sms_pkg::CMD_READE) || (cmd == sms_pkg::CMD_READB);
  assign sts.search_done = !(lo < hi);

  // a body byte lands only while bytes are still owed and the arena has room
  assign body_go = (pending != '0) && (cursor < BW'(ARENA_BYTES));

  // header judgement
  logic [31:0] lim_e, lim_b;
  logic        hdr_ok;
  logic [63:0] tmask;
  always_comb begin
    lim_e = (32'(msg_limit) < ENTRIES) ? 32'(msg_limit) : 32'(ENTRIES);
    lim_b = (32'(byte_limit) < ARENA_BYTES) ? 32'(byte_limit) : 32'(ARENA_BYTES);
    hdr_ok = !(32'(count) >= lim_e) && !(32'(used) + 32'(blen) > lim_b)
             && (tlen != 4'd0) && !(32'(tlen) > MAX_TYPE_LEN)
             && !((count != '0) && (seq <= meta_q[MW-1 -: 64]));
    tmask = '0;
    for (int k = 0; k < 8; k++) if (k < int'(tlen)) tmask[k*8 +: 8] = 8'hFF;
  end

  always_comb begin
    mid = lo + ((hi - lo) >> 1);
    meta_ra = ctl.search_rd ? mid[EW-1:0] :
              ctl.hdr_rd ? EW'(count - CW'(1)) : EW'(idx);
  end

  always_ff @(posedge clk) begin
    if (ctl.search_rd || ctl.hdr_rd || ctl.exec) meta_q <= meta_mem[meta_ra];
    if (ctl.exec) byte_q <= arena[AW'(addr)];
    if (ctl.hdr_commit && hdr_ok)
      meta_mem[EW'(count)] <= {seq, when, tbytes & tmask, tlen, 16'(used), blen};
    if (ctl.exec && cmd == sms_pkg::CMD_BODY && body_go)
      arena[AW'(cursor)] <= dbyte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; used <= '0; cursor <= '0; pending <= '0; drops <= '0;
      lo <= '0; hi <= '0; ok <= 1'b0; ok_read <= 1'b0;
    end else begin
      if (ctl.load) begin
        lo <= '0;
        hi <= count;
      end
      if (ctl.search_upd) begin
        if (mid < CW'(ENTRIES) && meta_q[MW-1 -: 64] < seq) lo <= mid + CW'(1);
        else hi <= mid;
      end
      if (ctl.exec) begin
        ok <= (cmd == sms_pkg::CMD_CLEAR) || ((cmd == sms_pkg::CMD_BODY) && body_go);
        unique case (cmd)
          sms_pkg::CMD_CLEAR: begin
            count <= '0; used <= '0; cursor <= '0; pending <= '0;
          end
          sms_pkg::CMD_BODY: if (body_go) begin
            cursor <= cursor + BW'(1); pending <= pending - 17'd1;
          end
          sms_pkg::CMD_READE:
            ok_read <= (CW'(idx) < count) && (32'(idx) < ENTRIES);
          sms_pkg::CMD_READB:
            ok_read <= (32'(addr) < 32'(used)) && (32'(addr) < ARENA_BYTES);
          default: ;
        endcase
      end
      if (ctl.hdr_commit) begin
        ok <= hdr_ok;
        if (hdr_ok) begin
          cursor <= used; pending <= blen; used <= used + BW'(blen);
          count <= count + CW'(1);
        end else begin
          pending <= '0;
          if (drops != 32'hFFFF_FFFF) drops <= drops + 32'd1;
        end
      end
    end
  end

  logic [294:0] r;
  always_comb begin
    r = '0;
    unique case (cmd)
      sms_pkg::CMD_CLEAR, sms_pkg::CMD_HEADER, sms_pkg::CMD_BODY: r[0] = ok;
      sms_pkg::CMD_LOWER: begin r[0] = 1'b1; r[11:1] = 11'(lo); end
      sms_pkg::CMD_READE: if (ok_read) begin
        r[0] = 1'b1;
        r[75:12]   = meta_q[MW-1 -: 64];
        r[139:76]  = meta_q[MW-65 -: 64];
        r[203:140] = meta_q[MW-129 -: 64];
        r[207:204] = meta_q[36:33];
        r[223:208] = meta_q[32:17];
        r[240:224] = meta_q[16:0];
      end
      sms_pkg::CMD_READB: if (ok_read) begin r[0] = 1'b1; r[248:241] = byte_q; end
      default: ;
    endcase
    r[259:249] = 11'(count);
    r[291:260] = drops;
  end

  always_ff @(posedge clk) if (ctl.finish) result <= r;
endmodule

FILE: tb/tb_sequenced_message_store_top.sv
// Self-checking testbench for the sequenced message store top level.
`timescale 1ns / 1ps
module tb_sequenced_message_store_top;

  // Command codes outside the package enum; the block must treat them as no-ops.
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int N_ENT   = 1024;
  localparam int N_ARENA = 65536;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int N_DIR = 29;

  // Request layout, highest field first so the packed struct matches s_tdata.
  typedef struct packed {
    logic [15:0]        byte_address;
    logic [9:0]         entry_index;
    logic [7:0]         data_byte;
    logic [16:0]        body_len;
    logic signed [63:0] send_time;
    logic [3:0]         type_count;
    logic [63:0]        type_bytes;
    logic [63:0]        seq;
    logic [2:0]         cmd;
  } req_t;

  typedef struct packed {
    logic [31:0]        dropped_count;
    logic [10:0]        entry_count;
    logic [7:0]         out_byte;
    logic [16:0]        body_length;
    logic [15:0]        body_offset;
    logic [3:0]         out_type_count;
    logic [63:0]        out_type_bytes;
    logic signed [63:0] out_send_time;
    logic [63:0]        out_seq;
    logic [10:0]        position;
    logic               accepted;
  } res_t;

  // One row of the directed table; fixed rows carry a typed expectation
  // (all entry/byte fields zero), the rest go through the predictor.
  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] seq;
    logic [63:0] tbytes;
    logic [3:0]  tlen;
    logic [63:0] ns;
    logic [16:0] blen;
    logic [7:0]  dbyte;
    logic [9:0]  idx;
    logic [15:0] addr;
    bit          fixed;
    bit          x_acc;
    logic [10:0] x_pos;
    logic [10:0] x_cnt;
    logic [31:0] x_drop;
  } row_t;

  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NSMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NSMIN = 64'h8000_0000_0000_0000;

  row_t dir_tab [N_DIR] = '{
    // fresh store: everything refused or empty
    '{sms_pkg::CMD_READE,  0, 0, 0, 0, 0, 0, 0, 0,          1, 0, 0, 0, 0},
    '{sms_pkg::CMD_READB,  0, 0, 0, 0, 0, 0, 0, 0,          1, 0, 0, 0, 0},
    '{sms_pkg::CMD_LOWER,  5, 0, 0, 0, 0, 0, 0, 0,          1, 1, 0, 0, 0},
    '{sms_pkg::CMD_BODY,   0, 0, 0, 0, 0, 8'hA5, 0, 0,      1, 0, 0, 0, 0},
    '{CMD_SPARE6, ALL1, ALL1, 15, ALL1, 17'h1FFFF, 8'hFF, 10'h3FF, 16'hFFFF,
      1, 0, 0, 0, 0},
    '{CMD_SPARE7, 0, 0, 0, 0, 0, 0, 0, 0,          1, 0, 0, 0, 0},
    // bad type lengths: each bumps the drop count
    '{sms_pkg::CMD_HEADER, 1, 64'h41, 0, 0, 0, 0, 0, 0,     1, 0, 0, 0, 1},
    '{sms_pkg::CMD_HEADER, 1, 64'h41, 9, 0, 0, 0, 0, 0,     1, 0, 0, 0, 2},
    '{sms_pkg::CMD_HEADER, 1, 64'h41, 15, 0, 0, 0, 0, 0,    1, 0, 0, 0, 3},
    // full-length type, two body bytes at the extremes
    '{sms_pkg::CMD_HEADER, 10, ALL1, 8, NSMAX, 2, 0, 0, 0,  0, 0, 0, 0, 0},
    '{sms_pkg::CMD_BODY,   0, 0, 0, 0, 0, 8'h00, 0, 0,      0, 0, 0, 0, 0},
    '{sms_pkg::CMD_BODY,   0, 0, 0, 0, 0, 8'hFF, 0, 0,      0, 0, 0, 0, 0},
    '{sms_pkg::CMD_BODY,   0, 0, 0, 0, 0, 8'h55, 0, 0,      1, 0, 0, 1, 3},
    // repeated sequence is refused
    '{sms_pkg::CMD_HEADER, 10, 64'h42, 1, 0, 0, 0, 0, 0,    1, 0, 0, 1, 4},
    // short type: high bytes must come back as zero
    '{sms_pkg::CMD_HEADER, ALL1, 64'h1122_3344_5566_7788, 3, NSMIN, 0, 0, 0, 0,
      0, 0, 0, 0, 0},
    '{sms_pkg::CMD_READE,  0, 0, 0, 0, 0, 0, 0, 0,          0, 0, 0, 0, 0},
    '{sms_pkg::CMD_READE,  0, 0, 0, 0, 0, 0, 1, 0,          0, 0, 0, 0, 0},
    '{sms_pkg::CMD_READE,  0, 0, 0, 0, 0, 0, 2, 0,          1, 0, 0, 2, 4},
    '{sms_pkg::CMD_READB,  0, 0, 0, 0, 0, 0, 0, 0,          0, 0, 0, 0, 0},
    '{sms_pkg::CMD_READB,  0, 0, 0, 0, 0, 0, 0, 1,          0, 0, 0, 0, 0},
    '{sms_pkg::CMD_READB,  0, 0, 0, 0, 0, 0, 0, 2,          1, 0, 0, 2, 4},
    '{sms_pkg::CMD_LOWER,  0, 0, 0, 0, 0, 0, 0, 0,          0, 0, 0, 0, 0},
    '{sms_pkg::CMD_LOWER,  11, 0, 0, 0, 0, 0, 0, 0,         0, 0, 0, 0, 0},
    '{sms_pkg::CMD_LOWER,  ALL1, 0, 0, 0, 0, 0, 0, 0,       0, 0, 0, 0, 0},
    // clear keeps the drop count
    '{sms_pkg::CMD_CLEAR,  0, 0, 0, 0, 0, 0, 0, 0,          1, 1, 0, 0, 4},
    // reserve the whole arena, then a zero-length body whose offset wraps
    '{sms_pkg::CMD_HEADER, 0, 64'h5A, 1, 0, 17'h10000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{sms_pkg::CMD_HEADER, 1, 64'h5B, 1, 0, 0, 0, 0, 0,     0, 0, 0, 0, 0},
    '{sms_pkg::CMD_READE,  0, 0, 0, 0, 0, 0, 1, 0,          0, 0, 0, 0, 0},
    // drop the abandoned reservation before random traffic
    '{sms_pkg::CMD_CLEAR,  0, 0, 0, 0, 0, 0, 0, 0,          1, 1, 0, 0, 4}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [295:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = '0;
  logic [16:0]  cfg_data = '0;

  sequenced_message_store_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the store.
  logic [63:0] sh_seq   [N_ENT];
  logic [63:0] sh_time  [N_ENT];
  logic [63:0] sh_type  [N_ENT];
  logic [3:0]  sh_tlen  [N_ENT];
  logic [15:0] sh_off   [N_ENT];
  logic [16:0] sh_len   [N_ENT];
  logic [7:0]  sh_arena [N_ARENA];
  bit          sh_known [N_ARENA];  // arena byte written at least once
  int unsigned sh_count, sh_used, sh_drops, sh_pending, sh_cursor;
  int unsigned lim_msgs, lim_bytes;

  res_t        expected_q [$];
  int          fail_cnt = 0;
  int unsigned n_req = 0, n_results = 0, n_hdr_ok = 0, n_refused = 0;
  int unsigned n_search = 0;
  bit          calm = 1'b0;   // no idling on either side while set
  int unsigned cycles = 0;

  task automatic store_model(input req_t q, output res_t e);
    int unsigned lo, hi, mid, le, lb;
    logic [63:0] mask;
    e = '0;
    case (q.cmd)
      sms_pkg::CMD_CLEAR: begin
        sh_count = 0; sh_used = 0; sh_pending = 0; sh_cursor = 0;
        e.accepted = 1'b1;
      end
      sms_pkg::CMD_HEADER: begin
        le = (lim_msgs < N_ENT) ? lim_msgs : N_ENT;
        lb = (lim_bytes < N_ARENA) ? lim_bytes : N_ARENA;
        sh_pending = 0;
        if (sh_count >= le || sh_used + q.body_len > lb || q.type_count == 0 ||
            q.type_count > 8 || (sh_count > 0 && q.seq <= sh_seq[sh_count-1])) begin
          if (sh_drops != 32'hFFFF_FFFF) sh_drops++;
          n_refused++;
        end else begin
          mask = (q.type_count >= 8) ? ALL1 : ((64'd1 << (8 * q.type_count)) - 64'd1);
          sh_seq[sh_count]  = q.seq;
          sh_time[sh_count] = q.send_time;
          sh_type[sh_count] = q.type_bytes & mask;
          sh_tlen[sh_count] = q.type_count;
          sh_off[sh_count]  = sh_used[15:0];
          sh_len[sh_count]  = q.body_len;
          sh_cursor  = sh_used;
          sh_pending = q.body_len;
          sh_used   += q.body_len;
          sh_count++;
          e.accepted = 1'b1;
          n_hdr_ok++;
        end
      end
      sms_pkg::CMD_BODY: begin
        if (sh_pending > 0 && sh_cursor < N_ARENA) begin
          sh_arena[sh_cursor] = q.data_byte;
          sh_known[sh_cursor] = 1'b1;
          sh_cursor++;
          sh_pending--;
          e.accepted = 1'b1;
        end
      end
      sms_pkg::CMD_LOWER: begin
        lo = 0; hi = sh_count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (sh_seq[mid] < q.seq) lo = mid + 1;
          else hi = mid;
        end
        e.accepted = 1'b1;
        e.position = lo[10:0];
        n_search++;
      end
      sms_pkg::CMD_READE: begin
        if (q.entry_index < sh_count) begin
          e.accepted       = 1'b1;
          e.out_seq        = sh_seq[q.entry_index];
          e.out_send_time  = sh_time[q.entry_index];
          e.out_type_bytes = sh_type[q.entry_index];
          e.out_type_count = sh_tlen[q.entry_index];
          e.body_offset    = sh_off[q.entry_index];
          e.body_length    = sh_len[q.entry_index];
        end
      end
      sms_pkg::CMD_READB: begin
        if (q.byte_address < sh_used) begin
          e.accepted = 1'b1;
          e.out_byte = sh_arena[q.byte_address];
        end
      end
      default: ;
    endcase
    e.entry_count   = sh_count[10:0];
    e.dropped_count = sh_drops;
  endtask

  // Present one request, wait for the handshake, then log its expectation.
  task automatic send_request(input req_t q, input bit fixed, input res_t typed_res);
    int unsigned gap;
    res_t e;
    gap = calm ? 0 : (($urandom_range(0, 99) < 6) ? $urandom_range(15, 60)
                                                    : $urandom_range(0, 2));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, q};
    do @(posedge clk); while (!s_tready);
    store_model(q, e);
    expected_q.push_back(fixed ? typed_res : e);
    n_req++;
  endtask

  // Write one register; release the channel before returning.
  task automatic write_reg(input logic [0:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[16:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == sms_pkg::REG_MSG_LIMIT) lim_msgs = val;
    else lim_bytes = val;
    @(posedge clk);
  endtask

  // Hold until every request has been answered, then let the block settle.
  task automatic drain;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  // Build the next random request from the current shadow state.
  task automatic pick_request(output req_t q);
    int unsigned p, k;
    q.cmd = sms_pkg::CMD_LOWER;
    q.seq = rand64(); q.type_bytes = rand64(); q.send_time = rand64();
    q.type_count = 4'($urandom); q.body_len = 17'($urandom); q.data_byte = 8'($urandom);
    q.entry_index = 10'($urandom); q.byte_address = 16'($urandom);
    p = $urandom_range(0, 99);
    if (sh_pending > 0 && p < 80) begin
      q.cmd = sms_pkg::CMD_BODY;
    end else if (p < 45) begin
      q.cmd = sms_pkg::CMD_HEADER;
      if (sh_count > 0) begin
        k = $urandom_range(0, 99);
        if (k < 6) q.seq = sh_seq[sh_count-1] - $urandom_range(0, 1);
        else if (k < 10)
          q.seq = sh_seq[sh_count-1] + rand64() % (ALL1 - sh_seq[sh_count-1] + 1);
        else q.seq = sh_seq[sh_count-1] + $urandom_range(1, 1000);
        if (sh_seq[sh_count-1] == ALL1 && k >= 6) q.seq = ALL1;
      end
      q.type_count = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(1, 8));
      q.body_len = ($urandom_range(0, 39) == 0) ? 17'($urandom_range(0, 65536))
                                                : 17'($urandom_range(0, 6));
    end else if (p < 58) begin
      q.cmd = sms_pkg::CMD_LOWER;
      if (sh_count > 0 && $urandom_range(0, 3) != 0)
        q.seq = sh_seq[$urandom_range(0, sh_count-1)] + $urandom_range(0, 2) - 1;
    end else if (p < 72) begin
      q.cmd = sms_pkg::CMD_READE;
      if (sh_count > 0 && $urandom_range(0, 4) != 0)
        q.entry_index = 10'($urandom_range(0, sh_count-1));
    end else if (p < 86) begin
      q.cmd = sms_pkg::CMD_READB;
      if (sh_used > 0 && $urandom_range(0, 4) != 0)
        q.byte_address = 16'($urandom_range(0, (sh_used > N_ARENA ? N_ARENA : sh_used) - 1));
      // never touch an arena byte that was reserved but never written
      if (q.byte_address < sh_used && !sh_known[q.byte_address]) q.cmd = sms_pkg::CMD_LOWER;
    end else if (p < 90) begin
      q.cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
    end else if (p < 94) begin
      q.cmd = sms_pkg::CMD_BODY;
    end else if (p < 97) begin
      q.cmd = sms_pkg::CMD_CLEAR;
    end else begin
      q.cmd = sms_pkg::CMD_HEADER;
    end
    // a huge reservation that would be abandoned: at random, clear it away when the arena is nearly full
    if (sh_used >= N_ARENA - 8 && q.cmd != sms_pkg::CMD_BODY && $urandom_range(0, 1))
      q.cmd = sms_pkg::CMD_CLEAR;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] got);
    if (exp_v !== got) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got);
      fail_cnt++;
    end
  endtask

  // Result side: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    res_t r, e;
    if (!rst && m_tvalid && m_tready) begin
      r = m_tdata[291:0];
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result arrived with nothing outstanding");
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        check_field("accepted", e.accepted, r.accepted);
        check_field("position", e.position, r.position);
        check_field("out_seq", e.out_seq, r.out_seq);
        check_field("out_send_time", e.out_send_time, r.out_send_time);
        check_field("out_type_bytes", e.out_type_bytes, r.out_type_bytes);
        check_field("out_type_count", e.out_type_count, r.out_type_count);
        check_field("body_offset", e.body_offset, r.body_offset);
        check_field("body_length", e.body_length, r.body_length);
        check_field("out_byte", e.out_byte, r.out_byte);
        check_field("entry_count", e.entry_count, r.entry_count);
        check_field("dropped_count", e.dropped_count, r.dropped_count);
      end
    end
  end

  // Receiver back-pressure: runs of ready and stall, mostly short.
  initial begin
    int unsigned run;
    forever begin
      if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        run = ($urandom_range(0, 99) < 5) ? $urandom_range(10, 50) : $urandom_range(1, 4);
        m_tready <= $urandom_range(0, 2) != 0;
        repeat (run) @(posedge clk);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Random phases: message limit, byte limit, request count, no-idle flag.
  int unsigned ph_msgs  [7] = '{1024, 0,    5,   1024, 3,     1024, 1024};
  int unsigned ph_bytes [7] = '{65536, 0,   40,  300,  65536, 0,    65536};
  int unsigned ph_items [7] = '{200,  40,   120, 150,  100,   60,   180};
  bit          ph_calm  [7] = '{0,    0,    1,   0,    0,     0,    0};

  initial begin
    req_t q;
    res_t t;
    lim_msgs = 1024; lim_bytes = 65536;
    sh_count = 0; sh_used = 0; sh_drops = 0; sh_pending = 0; sh_cursor = 0;
    foreach (sh_known[i]) sh_known[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table at the reset limits.
    for (int i = 0; i < N_DIR; i++) begin
      q = '0;
      q.cmd = dir_tab[i].cmd;           q.seq = dir_tab[i].seq;
      q.type_bytes = dir_tab[i].tbytes; q.type_count = dir_tab[i].tlen;
      q.send_time = dir_tab[i].ns;      q.body_len = dir_tab[i].blen;
      q.data_byte = dir_tab[i].dbyte;   q.entry_index = dir_tab[i].idx;
      q.byte_address = dir_tab[i].addr;
      t = '0;
      t.accepted = dir_tab[i].x_acc;      t.position = dir_tab[i].x_pos;
      t.entry_count = dir_tab[i].x_cnt;   t.dropped_count = dir_tab[i].x_drop;
      send_request(q, dir_tab[i].fixed, t);
    end

    // Random traffic, one limit setting per phase.
    for (int ph = 0; ph < 7; ph++) begin
      s_tvalid <= 1'b0;
      drain();
      write_reg(sms_pkg::REG_MSG_LIMIT, ph_msgs[ph]);
      write_reg(sms_pkg::REG_BYTE_LIMIT, ph_bytes[ph]);
      calm = ph_calm[ph];
      for (int n = 0; n < ph_items[ph]; n++) begin
        pick_request(q);
        send_request(q, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;
    drain();

    $display("covered %0d requests, %0d results: %0d headers stored, %0d refused, %0d searches",
             n_req, n_results, n_hdr_ok, n_refused, n_search);
    $display("limit settings from zero to full; idle and stall gaps on both sides");
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
